// ----- rtl/core/dual_servo_slew_stepper_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-joint servo slew stepper
// Shorthand for the same-cycle and next-cycle implication checks used by
// the top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_SERVO_SLEW_STEPPER_MACROS_SVH
`define DUAL_SERVO_SLEW_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo slew stepper package
// Request and register codes, controller commands, reset values and the
// clamping helpers shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_MOVE   = 2'd1,
        REQ_ABORT  = 2'd2,
        REQ_IGNORE = 2'd3
    } req_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_J1_MIN     = 3'd0,
        CFG_J1_MAX     = 3'd1,
        CFG_J2_MIN     = 3'd2,
        CFG_J2_MAX     = 3'd3,
        CFG_MIN_PERIOD = 3'd4,
        CFG_PULSE_BASE = 3'd5
    } cfg_idx_t;

    // Datapath operations, one per cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_GOAL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FINISH,
        OP_ABORT,
        OP_REPORT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;   // load the result register this cycle
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic diff_zero;
    } status_t;

    localparam int DEG_W    = 8;
    localparam int PULSE_W  = 9;
    localparam int TGT_W    = 11;
    localparam int PERIOD_W = 24;
    localparam int CFG_W    = 24;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;
    localparam int DIV_STEPS = PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    localparam logic [DEG_W-1:0]    RST_J1_MIN     = 8'd70;
    localparam logic [DEG_W-1:0]    RST_J1_MAX     = 8'd155;
    localparam logic [DEG_W-1:0]    RST_J2_MIN     = 8'd10;
    localparam logic [DEG_W-1:0]    RST_J2_MAX     = 8'd180;
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD = 24'd5000;
    localparam logic [DEG_W-1:0]    RST_PULSE_BASE = 8'd55;
    localparam logic [DEG_W-1:0]    RST_POS_ONE    = 8'd100;
    localparam logic [DEG_W-1:0]    RST_POS_TWO    = 8'd105;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 24'd5000;

    // Raise to lo first, then lower to hi, so hi wins when lo > hi.
    function automatic logic [DEG_W-1:0] clamp_deg(input logic signed [TGT_W-1:0] v,
                                                   input logic [DEG_W-1:0] lo,
                                                   input logic [DEG_W-1:0] hi);
        logic signed [TGT_W-1:0] r;
        r = v;
        if (r < $signed({3'b000, lo})) r = $signed({3'b000, lo});
        if (r > $signed({3'b000, hi})) r = $signed({3'b000, hi});
        return r[DEG_W-1:0];
    endfunction

    // One degree toward the goal, then clamped to the current limits.
    function automatic logic [DEG_W-1:0] step_toward(input logic [DEG_W-1:0] pos,
                                                     input logic [DEG_W-1:0] goal,
                                                     input logic [DEG_W-1:0] lo,
                                                     input logic [DEG_W-1:0] hi);
        logic signed [TGT_W-1:0] p;
        p = $signed({3'b000, pos});
        if (goal > pos) p = p + 11'sd1;
        else            p = p - 11'sd1;
        return clamp_deg(p, lo, hi);
    endfunction

endpackage

// ----- rtl/core/dss_datapath.sv -----
// ----------------------------------------------------------------------------
// Servo slew stepper datapath
// Holds limits, positions, goals, step timing, a restoring divider and the
// result register; executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module dss_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dss_pkg::cmd_t                     cmd,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]         cfg_data,
    input  logic signed [dss_pkg::TGT_W-1:0]  target_joint1,
    input  logic signed [dss_pkg::TGT_W-1:0]  target_joint2,
    input  logic [dss_pkg::PERIOD_W-1:0]      move_duration,
    output dss_pkg::status_t                  status,
    output logic [dss_pkg::OUT_W-1:0]         result
);

    localparam int DW = dss_pkg::DEG_W;
    localparam int PW = dss_pkg::PERIOD_W;

    logic [DW-1:0] j1_min_reg, j1_min_next, j1_max_reg, j1_max_next;
    logic [DW-1:0] j2_min_reg, j2_min_next, j2_max_reg, j2_max_next;
    logic [PW-1:0] min_period_reg, min_period_next;
    logic [DW-1:0] pulse_base_reg, pulse_base_next;

    logic [DW-1:0] pos1_reg, pos1_next, pos2_reg, pos2_next;
    logic [DW-1:0] goal1_reg, goal1_next, goal2_reg, goal2_next;
    logic [PW-1:0] period_reg, period_next, count_reg, count_next;
    logic          busy_reg, busy_next;

    logic [DW-1:0] diff_reg, diff_next, rem_reg, rem_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [dss_pkg::OUT_W-1:0] result_reg, result_next;

    logic [DW-1:0]  d1, d2, diff_max;
    logic [DW:0]    rem_sh, rem_sub;
    logic           rem_ge, diff_zero;
    logic [PW-1:0]  per_raw, per_fin, reload;
    logic [DW-1:0]  p1_step, p2_step;
    logic           w1_can, w2_can, busy_after, w1, w2;
    logic [dss_pkg::PULSE_W-1:0] pulse1, pulse2;

    assign d1       = (goal1_reg > pos1_reg) ? goal1_reg - pos1_reg : pos1_reg - goal1_reg;
    assign d2       = (goal2_reg > pos2_reg) ? goal2_reg - pos2_reg : pos2_reg - goal2_reg;
    assign diff_max = (d1 > d2) ? d1 : d2;

    // One quotient bit per step.
    assign rem_sh  = {rem_reg, quo_reg[PW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, diff_reg});
    assign rem_sub = rem_sh - {1'b0, diff_reg};

    assign diff_zero = (diff_reg == '0);
    assign per_raw   = diff_zero ? dss_pkg::PERIOD_MAX : quo_reg;
    assign per_fin   = (per_raw < min_period_reg) ? min_period_reg : per_raw;
    assign reload    = (cmd.op == dss_pkg::OP_FINISH) ? per_fin : period_reg;

    assign w1_can  = (pos1_reg != goal1_reg);
    assign w2_can  = (pos2_reg != goal2_reg);
    assign p1_step = w1_can ? dss_pkg::step_toward(pos1_reg, goal1_reg, j1_min_reg, j1_max_reg)
                            : pos1_reg;
    assign p2_step = w2_can ? dss_pkg::step_toward(pos2_reg, goal2_reg, j2_min_reg, j2_max_reg)
                            : pos2_reg;
    assign busy_after = (p1_step != goal1_reg) || (p2_step != goal2_reg);

    always_comb begin
        j1_min_next     = j1_min_reg;
        j1_max_next     = j1_max_reg;
        j2_min_next     = j2_min_reg;
        j2_max_next     = j2_max_reg;
        min_period_next = min_period_reg;
        pulse_base_next = pulse_base_reg;
        pos1_next   = pos1_reg;
        pos2_next   = pos2_reg;
        goal1_next  = goal1_reg;
        goal2_next  = goal2_reg;
        period_next = period_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        diff_next   = diff_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        w1          = 1'b0;
        w2          = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                dss_pkg::CFG_J1_MIN:     j1_min_next     = cfg_data[DW-1:0];
                dss_pkg::CFG_J1_MAX:     j1_max_next     = cfg_data[DW-1:0];
                dss_pkg::CFG_J2_MIN:     j2_min_next     = cfg_data[DW-1:0];
                dss_pkg::CFG_J2_MAX:     j2_max_next     = cfg_data[DW-1:0];
                dss_pkg::CFG_MIN_PERIOD: min_period_next = cfg_data[PW-1:0];
                dss_pkg::CFG_PULSE_BASE: pulse_base_next = cfg_data[DW-1:0];
                default: ;
            endcase
        end

        unique case (cmd.op)
            dss_pkg::OP_TICK: begin
                if (busy_reg) begin
                    if (count_reg <= 24'd1) begin
                        pos1_next  = p1_step;
                        pos2_next  = p2_step;
                        w1         = w1_can;
                        w2         = w2_can;
                        busy_next  = busy_after;
                        count_next = busy_after ? reload : '0;
                    end else begin
                        count_next = count_reg - 24'd1;
                    end
                end
            end
            dss_pkg::OP_GOAL: begin
                goal1_next = dss_pkg::clamp_deg(target_joint1, j1_min_reg, j1_max_reg);
                goal2_next = dss_pkg::clamp_deg(target_joint2, j2_min_reg, j2_max_reg);
                quo_next   = move_duration;
            end
            dss_pkg::OP_DIV_INIT: begin
                diff_next = diff_max;
                rem_next  = '0;
            end
            dss_pkg::OP_DIV_STEP: begin
                rem_next = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                quo_next = {quo_reg[PW-2:0], rem_ge};
            end
            dss_pkg::OP_FINISH: begin
                period_next = per_fin;
                if (!diff_zero) begin
                    pos1_next  = p1_step;
                    pos2_next  = p2_step;
                    w1         = w1_can;
                    w2         = w2_can;
                    busy_next  = busy_after;
                    count_next = busy_after ? reload : '0;
                end else begin
                    busy_next  = 1'b0;
                    count_next = '0;
                end
            end
            dss_pkg::OP_ABORT: begin
                goal1_next = pos1_reg;
                goal2_next = pos2_reg;
                busy_next  = 1'b0;
                count_next = '0;
            end
            dss_pkg::OP_NONE, dss_pkg::OP_REPORT: ;
            default: ;
        endcase
    end

    assign pulse1 = {1'b0, pulse_base_reg} + {1'b0, pos1_next};
    assign pulse2 = {1'b0, pulse_base_reg} + {1'b0, pos2_next};

    always_comb begin
        result_next = result_reg;
        if (cmd.emit) begin
            result_next = {3'b000, busy_next, w2, w1, pulse2, pulse1, pos2_next, pos1_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j1_min_reg     <= dss_pkg::RST_J1_MIN;
            j1_max_reg     <= dss_pkg::RST_J1_MAX;
            j2_min_reg     <= dss_pkg::RST_J2_MIN;
            j2_max_reg     <= dss_pkg::RST_J2_MAX;
            min_period_reg <= dss_pkg::RST_MIN_PERIOD;
            pulse_base_reg <= dss_pkg::RST_PULSE_BASE;
            pos1_reg       <= dss_pkg::RST_POS_ONE;
            pos2_reg       <= dss_pkg::RST_POS_TWO;
            goal1_reg      <= dss_pkg::RST_POS_ONE;
            goal2_reg      <= dss_pkg::RST_POS_TWO;
            period_reg     <= dss_pkg::RST_PERIOD;
            count_reg      <= '0;
            busy_reg       <= 1'b0;
        end else begin
            j1_min_reg     <= j1_min_next;
            j1_max_reg     <= j1_max_next;
            j2_min_reg     <= j2_min_next;
            j2_max_reg     <= j2_max_next;
            min_period_reg <= min_period_next;
            pulse_base_reg <= pulse_base_next;
            pos1_reg       <= pos1_next;
            pos2_reg       <= pos2_next;
            goal1_reg      <= goal1_next;
            goal2_reg      <= goal2_next;
            period_reg     <= period_next;
            count_reg      <= count_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

    assign status.busy      = busy_reg;
    assign status.diff_zero = diff_zero;
    assign result           = result_reg;

endmodule

// ----- rtl/core/dss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Servo slew stepper controller
// Accepts items, sequences the move division and owns the result valid flag.
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        s_tuser,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  dss_pkg::status_t  status,
    output dss_pkg::cmd_t     cmd
);

    localparam int CNT_W = $clog2(dss_pkg::DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic               out_free;
    dss_pkg::req_t      req;

    assign out_free = !valid_reg || m_tready;
    assign req      = dss_pkg::req_t'(s_tuser);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = dss_pkg::OP_NONE;
        cmd.emit   = 1'b0;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    unique case (req)
                        dss_pkg::REQ_TICK: begin
                            cmd.op   = dss_pkg::OP_TICK;
                            cmd.emit = 1'b1;
                        end
                        dss_pkg::REQ_MOVE: begin
                            cmd.op     = dss_pkg::OP_GOAL;
                            state_next = S_INIT;
                        end
                        dss_pkg::REQ_ABORT: begin
                            cmd.op   = dss_pkg::OP_ABORT;
                            cmd.emit = 1'b1;
                        end
                        dss_pkg::REQ_IGNORE: begin
                            cmd.op   = dss_pkg::OP_REPORT;
                            cmd.emit = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                cmd.op     = dss_pkg::OP_DIV_INIT;
                cnt_next   = CNT_W'(dss_pkg::DIV_STEPS - 1);
                state_next = S_DIVIDE;
            end
            S_DIVIDE: begin
                // A zero distance needs no quotient; the period saturates.
                if (status.diff_zero) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.op = dss_pkg::OP_DIV_STEP;
                    if (cnt_reg == '0) state_next = S_FINISH;
                    else               cnt_next   = cnt_reg - CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.op     = dss_pkg::OP_FINISH;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.emit)      valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
        else               valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ----- rtl/core/dual_servo_slew_stepper.sv -----
// ----------------------------------------------------------------------------
// Two-joint servo slew stepper
// Walks two servo joints one degree at a time toward clamped targets, paced
// by microsecond ticks, and reports positions and pulse values per item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  s_        in         s_tvalid / s_tready  request kind, two targets, duration
//  m_        out        m_tvalid / m_tready  positions, pulses, step flags, moving
//  cfg_      in         cfg_valid / cfg_ready  register index and write data
//
// A tick, an abort or an ignored request is handled within the idle
// state, so ticks can stream at one item per cycle while the result side
// keeps up. A move runs through goal capture, divider setup, 24 restoring
// divider steps (one quotient bit each) and the finishing step; with zero
// distance the divider steps are skipped.
// The result register holds one item: while a result waits, no new item is
// accepted, and the input is taken in the same cycle as the result leaves.
// Reset is synchronous on aresetn low and restores the rest positions and
// the default limits; the configuration port is always ready.
//
`include "dual_servo_slew_stepper_macros.svh"

module dual_servo_slew_stepper (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input items.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // tdata, lowest bit up: target_joint1[10:0], target_joint2[21:11],
    // move_duration[45:22], zero fill [47:46].
    input  logic [dss_pkg::IN_W-1:0]   s_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]                 s_tuser,
    // Result items.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // tdata, lowest bit up: joint1_position[7:0], joint2_position[15:8],
    // joint1_pulse[24:16], joint2_pulse[33:25], joint1_written[34],
    // joint2_written[35], moving[36], zero fill [39:37].
    output logic [dss_pkg::OUT_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]  cfg_data
);

    dss_pkg::cmd_t    dp_cmd;
    dss_pkg::status_t dp_status;

    // Write only while idle, so writes never collide with a move; the block does not enforce this.
    assign cfg_ready = 1'b1;

    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    dss_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target_joint1 ($signed(s_tdata[10:0])),
        .target_joint2 ($signed(s_tdata[21:11])),
        .move_duration (s_tdata[45:22]),
        .status        (dp_status),
        .result        (m_tdata)
    );

    // A held result blocks new items.
    `DSS_ASSERT_NOW(a_hold_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "item accepted while result stalled")

    // The reported moving flag matches the live busy state while it waits.
    `DSS_ASSERT_NOW(a_moving_matches, aclk, aresetn, m_tvalid, m_tdata[36] == dp_status.busy, "moving flag disagrees with busy state")

    // A move produces no result in the cycle after it is accepted.
    `DSS_ASSERT_NEXT(a_move_no_early_result, aclk, aresetn, s_tvalid && s_tready && (s_tuser == dss_pkg::REQ_MOVE), !m_tvalid, "move result appeared too early")

endmodule

// ----- tb/sv/dual_servo_slew_stepper_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Self-checking bench for the two-joint servo slew stepper
// Streams tick, move, abort and ignored requests into the block under bursty
// input and stalling output, and predicts every result item from a
// cycle-free model of the joints. The model covers clamping, the step-period
// division and its floor and saturation, and the countdown between steps.
// The limit registers are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module dual_servo_slew_stepper_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 85;
    localparam int HOLD_CYCLES = 400;

    // One request as the bench sees it before packing onto the bus.
    typedef struct packed {
        dss_pkg::req_t      kind;
        logic signed [10:0] target_one;
        logic signed [10:0] target_two;
        logic [23:0]        duration;
    } servo_req_t;

    // One result item, laid out so that it maps bit for bit onto m_tdata[36:0].
    typedef struct packed {
        logic       moving;
        logic       wrote_two;
        logic       wrote_one;
        logic [8:0] pulse_two;
        logic [8:0] pulse_one;
        logic [7:0] pos_two;
        logic [7:0] pos_one;
    } joint_report_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [dss_pkg::IN_W-1:0]    s_tdata = '0;
    logic [1:0]                  s_tuser = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [dss_pkg::OUT_W-1:0]   m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [2:0]                  cfg_index = '0;
    logic [dss_pkg::CFG_W-1:0]   cfg_data = '0;

    dual_servo_slew_stepper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and results predicted but not yet seen.
    servo_req_t    pending_reqs[$];
    joint_report_t expected_reports[$];

    int error_count    = 0;
    int reqs_queued    = 0;
    int reqs_taken     = 0;
    int reports_seen   = 0;
    int steps_seen     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    // The bench's own copy of the joint state and of the limit registers.
    logic [7:0]  joint_pos_one, joint_pos_two, joint_goal_one, joint_goal_two;
    logic [23:0] step_gap, ticks_left;
    logic        in_motion;
    logic [7:0]  lim1_lo, lim1_hi, lim2_lo, lim2_hi, pulse_zero;
    logic [23:0] step_floor;

    // ------------------------------------------------------------------------
    // Joint model.
    // ------------------------------------------------------------------------

    // Rest positions and default limits, as the block holds them after reset.
    function automatic void rest_joints();
        lim1_lo        = 8'd70;
        lim1_hi        = 8'd155;
        lim2_lo        = 8'd10;
        lim2_hi        = 8'd180;
        step_floor     = 24'd5000;
        pulse_zero     = 8'd55;
        joint_pos_one  = 8'd100;
        joint_pos_two  = 8'd105;
        joint_goal_one = 8'd100;
        joint_goal_two = 8'd105;
        step_gap       = 24'd5000;
        ticks_left     = '0;
        in_motion      = 1'b0;
    endfunction

    function automatic void apply_register(input dss_pkg::cfg_idx_t idx,
                                           input logic [23:0] value);
        case (idx)
            dss_pkg::CFG_J1_MIN:     lim1_lo    = value[7:0];
            dss_pkg::CFG_J1_MAX:     lim1_hi    = value[7:0];
            dss_pkg::CFG_J2_MIN:     lim2_lo    = value[7:0];
            dss_pkg::CFG_J2_MAX:     lim2_hi    = value[7:0];
            dss_pkg::CFG_MIN_PERIOD: step_floor = value;
            dss_pkg::CFG_PULSE_BASE: pulse_zero = value[7:0];
            default: ;
        endcase
    endfunction

    // The lower limit is applied first, so the upper one wins when they cross.
    function automatic logic [7:0] limit_deg(input int v, input logic [7:0] lo,
                                             input logic [7:0] hi);
        int lo_i, hi_i, r;
        lo_i = int'(lo);
        hi_i = int'(hi);
        r    = v;
        if (r < lo_i) r = lo_i;
        if (r > hi_i) r = hi_i;
        return r[7:0];
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] pos, input logic [7:0] goal,
                                         input logic [7:0] lo, input logic [7:0] hi);
        int p;
        p = int'(pos);
        p = (goal > pos) ? p + 1 : p - 1;
        return limit_deg(p, lo, hi);
    endfunction

    // Moves every joint that is off its goal by one degree and rearms the count, or clears it once both have arrived.
    function automatic void take_step(inout joint_report_t r);
        if (joint_pos_one != joint_goal_one) begin
            joint_pos_one = nudge(joint_pos_one, joint_goal_one, lim1_lo, lim1_hi);
            r.wrote_one   = 1'b1;
        end
        if (joint_pos_two != joint_goal_two) begin
            joint_pos_two = nudge(joint_pos_two, joint_goal_two, lim2_lo, lim2_hi);
            r.wrote_two   = 1'b1;
        end
        ticks_left = step_gap;
        in_motion  = (joint_pos_one != joint_goal_one) || (joint_pos_two != joint_goal_two);
        if (!in_motion) ticks_left = '0;
    endfunction

    // Applies one request to the model and returns the result it produces.
    function automatic joint_report_t advance_servo(input servo_req_t rq);
        joint_report_t r;
        logic [7:0]    dist_one, dist_two, span;
        logic [23:0]   per;
        r = '0;
        case (rq.kind)
            dss_pkg::REQ_TICK: begin
                if (in_motion) begin
                    if (ticks_left <= 24'd1) take_step(r);
                    else                     ticks_left = ticks_left - 24'd1;
                end
            end
            dss_pkg::REQ_MOVE: begin
                joint_goal_one = limit_deg(int'(rq.target_one), lim1_lo, lim1_hi);
                joint_goal_two = limit_deg(int'(rq.target_two), lim2_lo, lim2_hi);
                dist_one = (joint_goal_one > joint_pos_one) ? joint_goal_one - joint_pos_one
                                                            : joint_pos_one - joint_goal_one;
                dist_two = (joint_goal_two > joint_pos_two) ? joint_goal_two - joint_pos_two
                                                            : joint_pos_two - joint_goal_two;
                span = (dist_one > dist_two) ? dist_one : dist_two;
                if (span != 0) per = rq.duration / span;
                else           per = dss_pkg::PERIOD_MAX;
                if (per < step_floor) per = step_floor;
                step_gap = per;
                if (span != 0) begin
                    take_step(r);
                end else begin
                    in_motion  = 1'b0;
                    ticks_left = '0;
                end
            end
            dss_pkg::REQ_ABORT: begin
                joint_goal_one = joint_pos_one;
                joint_goal_two = joint_pos_two;
                in_motion      = 1'b0;
                ticks_left     = '0;
            end
            default: ;
        endcase
        r.pos_one   = joint_pos_one;
        r.pos_two   = joint_pos_two;
        r.pulse_one = {1'b0, pulse_zero} + {1'b0, joint_pos_one};
        r.pulse_two = {1'b0, pulse_zero} + {1'b0, joint_pos_two};
        r.moving    = in_motion;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog.
    // ------------------------------------------------------------------------

    initial begin
        forever #10 aclk = ~aclk;
    end

    // The run is capped so that a hung handshake ends it as a failure.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offers queued requests in bursts of random length with random
    // gaps in between. A burst may run with no gap at all. The expected result
    // is computed at the edge where the request is taken.
    // ------------------------------------------------------------------------
    servo_req_t offer;
    int         burst_left = 1;
    int         gap_left   = 0;

    always @(posedge aclk) begin : sender
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(advance_servo(offer));
                reqs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offer = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, offer.duration, offer.target_two, offer.target_one};
                    s_tuser  <= offer.kind;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches at random between four ready patterns, each kept for a random stretch.
    // Once, after a few hundred results and while the sender still has plenty
    // queued, it holds off for a long stretch so the block backs up and stops
    // taking input.
    // ------------------------------------------------------------------------
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    int   rx_mode    = 0;
    int   mode_left  = 0;

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && reports_seen >= 300 && pending_reqs.size() > 30) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every result taken is compared against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        joint_report_t want, seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = joint_report_t'(m_tdata[36:0]);
            if (expected_reports.size() == 0) begin
                $error("result item arrived with no prediction waiting");
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("joint1_position", int'(want.pos_one),   int'(seen.pos_one));
                check_field("joint2_position", int'(want.pos_two),   int'(seen.pos_two));
                check_field("joint1_pulse",    int'(want.pulse_one), int'(seen.pulse_one));
                check_field("joint2_pulse",    int'(want.pulse_two), int'(seen.pulse_two));
                check_field("joint1_written",  int'(want.wrote_one), int'(seen.wrote_one));
                check_field("joint2_written",  int'(want.wrote_two), int'(seen.wrote_two));
                check_field("moving",          int'(want.moving),    int'(seen.moving));
            end
            reports_seen++;
            steps_seen += int'(seen.wrote_one) + int'(seen.wrote_two);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------

    task automatic push_req(input dss_pkg::req_t kind, input int t1, input int t2,
                            input int dur);
        servo_req_t rq;
        rq.kind       = kind;
        rq.target_one = 11'(t1);
        rq.target_two = 11'(t2);
        rq.duration   = 24'(dur);
        pending_reqs.push_back(rq);
        reqs_queued++;
    endtask

    // Returns at a rising edge once every queued request has been taken and
    // every predicted result has been checked.
    task automatic wait_drained();
        do @(posedge aclk);
        while (reqs_taken != reqs_queued || expected_reports.size() != 0);
    endtask

    // Leaves cfg_valid high between writes so it is never lowered and raised
    // in the same step; the caller lowers it after the last one.
    task automatic write_register(input dss_pkg::cfg_idx_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        apply_register(idx, value);
    endtask

    task automatic program_limits(input logic [7:0] j1_lo, input logic [7:0] j1_hi,
                                  input logic [7:0] j2_lo, input logic [7:0] j2_hi,
                                  input logic [23:0] floor_per, input logic [7:0] base);
        write_register(dss_pkg::CFG_J1_MIN, {16'd0, j1_lo});
        write_register(dss_pkg::CFG_J1_MAX, {16'd0, j1_hi});
        write_register(dss_pkg::CFG_J2_MIN, {16'd0, j2_lo});
        write_register(dss_pkg::CFG_J2_MAX, {16'd0, j2_hi});
        write_register(dss_pkg::CFG_MIN_PERIOD, floor_per);
        write_register(dss_pkg::CFG_PULSE_BASE, {16'd0, base});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed motion: a move with a short duration followed by a
    // run of ticks, so joints actually walk and often arrive. The rest is
    // moves with raw field values, moves that preempt a running one, aborts
    // in the middle of motion, ignored requests and stray ticks.
    task automatic queue_random_batch(input int count);
        int start, pick, n;
        start = reqs_queued;
        while (reqs_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_req(dss_pkg::REQ_MOVE, int'($urandom_range(0, 200)) - 10,
                         int'($urandom_range(0, 200)) - 10, $urandom_range(0, 300));
                n = $urandom_range(0, 60);
                repeat (n) push_req(dss_pkg::REQ_TICK, $urandom_range(0, 2047) - 1024,
                                    $urandom_range(0, 2047) - 1024, $urandom);
                if ($urandom_range(0, 4) == 0) push_req(dss_pkg::REQ_ABORT, 0, 0, 0);
            end else if (pick < 72) begin
                push_req(dss_pkg::REQ_MOVE, $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 2047) - 1024, $urandom);
                repeat ($urandom_range(0, 8)) push_req(dss_pkg::REQ_TICK, 0, 0, 0);
            end else if (pick < 82) begin
                push_req(dss_pkg::REQ_MOVE, $urandom_range(0, 180), $urandom_range(0, 180),
                         $urandom_range(0, 100));
                repeat ($urandom_range(0, 4)) push_req(dss_pkg::REQ_TICK, 0, 0, 0);
                push_req(dss_pkg::REQ_MOVE, $urandom_range(0, 180), $urandom_range(0, 180),
                         $urandom_range(0, 100));
                repeat ($urandom_range(0, 10)) push_req(dss_pkg::REQ_TICK, 0, 0, 0);
            end else if (pick < 88) begin
                push_req(dss_pkg::REQ_ABORT, $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 2047) - 1024, $urandom);
            end else if (pick < 94) begin
                push_req(dss_pkg::REQ_IGNORE, $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 2047) - 1024, $urandom);
            end else begin
                push_req(dss_pkg::REQ_TICK, 0, 0, 0);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] j1_lo, input logic [7:0] j1_hi,
                             input logic [7:0] j2_lo, input logic [7:0] j2_hi,
                             input logic [23:0] floor_per, input logic [7:0] base);
        program_limits(j1_lo, j1_hi, j2_lo, j2_hi, floor_per, base);
        queue_random_batch(PHASE_ITEMS);
        wait_drained();
    endtask

    initial begin
        rest_joints();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset limits. The first move asks for the
        // rest positions, so its distance is zero and the period saturates.
        push_req(dss_pkg::REQ_MOVE, 100, 105, 1234);
        push_req(dss_pkg::REQ_TICK, 0, 0, 0);
        // Extreme targets clamp to the limits; a zero duration hits the floor.
        push_req(dss_pkg::REQ_MOVE, -1024, 1023, 0);
        push_req(dss_pkg::REQ_TICK, 0, 0, 0);
        push_req(dss_pkg::REQ_TICK, 0, 0, 0);
        push_req(dss_pkg::REQ_IGNORE, 1023, -1024, 'hFFFFFF);
        // A new move while the previous one is still running, with the longest duration.
        push_req(dss_pkg::REQ_MOVE, 1023, -1024, 'hFFFFFF);
        push_req(dss_pkg::REQ_TICK, 0, 0, 0);
        push_req(dss_pkg::REQ_ABORT, 0, 0, 0);
        // Ticks after an abort change nothing.
        push_req(dss_pkg::REQ_TICK, 0, 0, 0);
        push_req(dss_pkg::REQ_MOVE, 0, 0, 1);
        push_req(dss_pkg::REQ_MOVE, -1, 1023, 'hFFFFFF);
        push_req(dss_pkg::REQ_ABORT, -1024, 1023, 'hABCDEF);
        push_req(dss_pkg::REQ_MOVE, 155, 10, 0);
        wait_drained();

        // Each setting leaves the joints where the last phase put them, so a
        // narrower window makes a joint outside it jump in on its next step.
        run_phase(8'd0,   8'd180, 8'd0,   8'd180, 24'd0,        8'd0);
        run_phase(8'd20,  8'd160, 8'd30,  8'd150, 24'd1,        8'd255);
        run_phase(8'd90,  8'd90,  8'd180, 8'd180, 24'd2,        8'd128);
        run_phase(8'd150, 8'd40,  8'd0,   8'd180, 24'd3,        8'd17);
        run_phase(8'd0,   8'd180, 8'd170, 8'd20,  24'd0,        8'd200);
        run_phase(8'd60,  8'd120, 8'd0,   8'd180, 24'hFFFFFF,   8'd99);
        run_phase(8'd0,   8'd180, 8'd0,   8'd180, 24'd4,        8'd255);
        run_phase(8'd70,  8'd155, 8'd10,  8'd180, 24'd1,        8'd55);

        // Let the block idle before closing, then check that no predicted result is left over.
        repeat (40) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $error("%0d predicted results never arrived", expected_reports.size());
            error_count++;
        end

        $display("Checked %0d result items from %0d requests under %0d limit settings.",
                 reports_seen, reqs_taken, settings_used + 1);
        $display("Joints took %0d single-degree steps; %0d mismatches found.",
                 steps_seen, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
